// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
// Set ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked at every rising edge out of reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`else

`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== sv/sgps_pkg.sv =====
package sgps_pkg;

    localparam int MAX_WIDTH_DEF   = 2048;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int PIX_W      = 8;
    localparam int FW_W       = 12;
    localparam int FH_W       = 16;
    localparam int OUT_COL_W  = 11;
    localparam int OUT_ROW_W  = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int RES_NUM    = 4;
    localparam int GAMMA_N    = 255;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 12'd640;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 16'd480;

    // Result kinds one input pixel may produce, in output order.
    // Also the bit index in job_t.mask.
    localparam logic [1:0] RES_ABOVE_LEFT = 2'd0;  // (x-1, y-1)
    localparam logic [1:0] RES_ABOVE_EDGE = 2'd1;  // (W-1, y-1)
    localparam logic [1:0] RES_LAST_LEFT  = 2'd2;  // (x-1, H-1)
    localparam logic [1:0] RES_LAST_EDGE  = 2'd3;  // (W-1, H-1), end of frame

    localparam logic [PIX_W-1:0] PIX_SAT = 8'hFF;

    // One classified input pixel: which results it produces and the
    // neighborhood they need (edge clamping already resolved).
    typedef struct packed {
        logic [RES_NUM-1:0]   mask;
        logic [OUT_COL_W-1:0] col;
        logic [OUT_ROW_W-1:0] row;
        logic [PIX_W-1:0]     up_prev;   // row above, column x-1
        logic [PIX_W-1:0]     up_cur;    // row above, column x
        logic [PIX_W-1:0]     cur_prev;  // current row, column x-1
        logic [PIX_W-1:0]     cur_cur;   // current row, column x
        logic [PIX_W-1:0]     al_left;   // left of (x-1, y-1)
        logic [PIX_W-1:0]     al_up;     // up of (x-1, y-1)
        logic [PIX_W-1:0]     ae_up;     // up of (x, y-1)
        logic [PIX_W-1:0]     ll_left;   // left of (x-1, y)
    } job_t;

    typedef struct packed {
        logic full;
        logic almost_full;
    } queue_status_t;

    typedef logic [GAMMA_N-1:0][PIX_W-1:0] gamma_rom_t;

    // gamma[i] = largest v with v^5 * 255 <= i^6, i.e. floor(255*(i/255)^1.2)
    function automatic gamma_rom_t build_gamma();
        gamma_rom_t        rom;
        longint unsigned   i6;
        longint unsigned   p5;
        longint unsigned   v64;
        longint unsigned   i64;
        int                g;
        for (int i = 0; i < GAMMA_N; i++)
        begin
            i64 = longint'(i);
            i6  = i64 * i64 * i64 * i64 * i64 * i64;
            g   = 0;
            for (int v = 1; v < GAMMA_N; v++)
            begin
                v64 = longint'(v);
                p5  = v64 * v64 * v64 * v64 * v64;
                if (p5 * 64'd255 <= i6)
                begin
                    g = v;
                end
            end
            rom[i] = PIX_W'(g);
        end
        return rom;
    endfunction

endpackage

// ===== sv/sgps_ram.sv =====
module sgps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/sgps_front.sv =====
module sgps_front #(
    parameter int MAX_WIDTH   = sgps_pkg::MAX_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [sgps_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [sgps_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [sgps_pkg::PIX_W-1:0]           pixel,
    output logic                                 push,
    output sgps_pkg::job_t                       push_job,
    input  sgps_pkg::queue_status_t              queue_status
);

    import sgps_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int WC_W  = ($clog2(MAX_WIDTH + 1) > FW_W) ? $clog2(MAX_WIDTH + 1) : FW_W;
    localparam logic [WC_W-1:0] W_MAX = WC_W'(MAX_WIDTH);
    localparam logic [WC_W-1:0] W_MIN = WC_W'(2);

    logic [FW_W-1:0]  frame_width_reg,  frame_width_next;
    logic [FH_W-1:0]  frame_height_reg, frame_height_next;
    logic [COL_W-1:0] col_reg,          col_next;
    logic [FH_W-1:0]  row_reg,          row_next;
    logic             s1_valid_reg;
    logic [PIX_W-1:0] s1_pixel_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic [FH_W-1:0]  s1_row_reg;
    logic             s1_last_col_reg;
    logic             s1_last_row_reg;
    // 0..2: column x-1 (top, mid, bottom row); 3..5: column x-2
    logic [PIX_W-1:0] win_reg  [6];
    logic [PIX_W-1:0] win_next [6];

    logic [WC_W-1:0]  fw_ext;
    logic [WC_W-1:0]  w_eff;
    logic [FH_W-1:0]  h_eff;
    logic             last_col;
    logic             last_row;
    logic             accept;

    logic [PIX_W-1:0] rd_one;
    logic [PIX_W-1:0] rd_two;
    logic [PIX_W-1:0] at, am, ab, bt, bm, bb, cm, cb;
    logic             x_nz, x_one, y_nz, r_zero;
    logic [RES_NUM-1:0] mask;

    // ---- position and effective frame size ----
    assign fw_ext = WC_W'(frame_width_reg);

    always_comb
    begin
        priority if (fw_ext < W_MIN)
            w_eff = W_MIN;
        else if (fw_ext > W_MAX)
            w_eff = W_MAX;
        else
            w_eff = fw_ext;
    end

    assign h_eff    = (frame_height_reg < FH_W'(2)) ? FH_W'(2) : frame_height_reg;
    assign last_col = (WC_W'(col_reg) == (w_eff - WC_W'(1)));
    assign last_row = (row_reg == (h_eff - FH_W'(1)));

    // One pixel can be in flight ahead of the queue.
    assign in_stall = s1_valid_reg ? queue_status.almost_full : queue_status.full;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        col_next          = col_reg;
        row_next          = row_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_next  = cfg_data[FW_W-1:0];
                REG_FRAME_HEIGHT: frame_height_next = cfg_data[FH_W-1:0];
                default:          frame_width_next  = frame_width_reg;
            endcase
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : (row_reg + FH_W'(1));
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
            col_reg          <= '0;
            row_reg          <= '0;
            s1_valid_reg     <= 1'b0;
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            frame_width_reg  <= frame_width_next;
            frame_height_reg <= frame_height_next;
            col_reg          <= col_next;
            row_reg          <= row_next;
            s1_valid_reg     <= accept;
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= win_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pixel_reg    <= pixel;
            s1_col_reg      <= col_reg;
            s1_row_reg      <= row_reg;
            s1_last_col_reg <= last_col;
            s1_last_row_reg <= last_row;
        end
    end

    // ---- line buffers: read at accept, written back in the next cycle ----
    sgps_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_row_one (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_col_reg),
        .wdata (ab),
        .raddr (col_reg),
        .rdata (rd_one)
    );

    sgps_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_row_two (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_col_reg),
        .wdata (am),
        .raddr (col_reg),
        .rdata (rd_two)
    );

    // ---- stage 1: window and classification ----
    assign at = rd_two;
    assign am = rd_one;
    assign ab = s1_pixel_reg;
    assign bt = win_reg[0];
    assign bm = win_reg[1];
    assign bb = win_reg[2];
    assign cm = win_reg[4];
    assign cb = win_reg[5];

    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            win_next[i] = win_reg[i];
        end
        if (s1_valid_reg)
        begin
            win_next[3] = bt;
            win_next[4] = bm;
            win_next[5] = bb;
            win_next[0] = at;
            win_next[1] = am;
            win_next[2] = ab;
        end
    end

    assign x_nz   = (s1_col_reg != '0);
    assign x_one  = (s1_col_reg == COL_W'(1));
    assign y_nz   = (s1_row_reg != '0);
    assign r_zero = (s1_row_reg == FH_W'(1));

    assign mask[RES_ABOVE_LEFT] = y_nz && x_nz;
    assign mask[RES_ABOVE_EDGE] = y_nz && s1_last_col_reg;
    assign mask[RES_LAST_LEFT]  = y_nz && s1_last_row_reg && x_nz;
    assign mask[RES_LAST_EDGE]  = y_nz && s1_last_row_reg && s1_last_col_reg;

    always_comb
    begin
        push_job.mask     = mask;
        push_job.col      = OUT_COL_W'(s1_col_reg);
        push_job.row      = s1_row_reg;
        push_job.up_prev  = bm;
        push_job.up_cur   = am;
        push_job.cur_prev = bb;
        push_job.cur_cur  = ab;
        // clamp-to-edge: left edge repeats the center, top edge the row itself
        push_job.al_left  = x_one  ? bm : cm;
        push_job.al_up    = r_zero ? bm : bt;
        push_job.ae_up    = r_zero ? am : at;
        push_job.ll_left  = x_one  ? bb : cb;
    end

    assign push = s1_valid_reg && (mask != '0);

endmodule

// ===== sv/sgps_queue.sv =====
`include "assert_macros.svh"

module sgps_queue #(
    parameter int DEPTH = sgps_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  sgps_pkg::job_t           push_job,
    output sgps_pkg::queue_status_t  status,
    output logic                     head_valid,
    output sgps_pkg::job_t           head_job,
    input  logic                     pop
);

    import sgps_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] AFULL_CNT = CNT_W'(DEPTH - 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : (wr_ptr_reg + PTR_W'(1));
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : (rd_ptr_reg + PTR_W'(1));
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    assign status.full        = (count_reg >= FULL_CNT);
    assign status.almost_full = (count_reg >= AFULL_CNT);
    assign head_valid         = (count_reg != '0);
    assign head_job           = mem_reg[rd_ptr_reg];

    // front-end stall logic must never overrun the queue
    `ASSERT_IMPL(a_no_overflow, clk, rst_n, push, !status.full || pop)
    `ASSERT_IMPL(a_no_underflow, clk, rst_n, pop, head_valid)
    `ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_reg <= FULL_CNT)

endmodule

// ===== sv/sgps_back.sv =====
`include "assert_macros.svh"

module sgps_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            head_valid,
    input  sgps_pkg::job_t                  head_job,
    output logic                            pop,
    output logic [sgps_pkg::PIX_W-1:0]      value,
    output logic [sgps_pkg::OUT_COL_W-1:0]  out_col,
    output logic [sgps_pkg::OUT_ROW_W-1:0]  out_row,
    output logic                            frame_end,
    output logic                            out_valid,
    input  logic                            out_stall
);

    import sgps_pkg::*;

    localparam gamma_rom_t GAMMA_ROM = build_gamma();

    logic [RES_NUM-1:0]   done_reg, done_next;
    logic                 out_valid_reg, out_valid_next;
    logic [PIX_W-1:0]     value_reg;
    logic [OUT_COL_W-1:0] out_col_reg;
    logic [OUT_ROW_W-1:0] out_row_reg;
    logic                 frame_end_reg;

    logic [RES_NUM-1:0]   rem;
    logic [1:0]           kind;
    logic [RES_NUM-1:0]   sel;
    logic                 last_one;
    logic                 load;

    logic [PIX_W-1:0]     op_c, op_l, op_u, op_r, op_d;
    logic [OUT_COL_W-1:0] res_col;
    logic [OUT_ROW_W-1:0] res_row;
    logic                 res_end;
    logic [PIX_W+1:0]     sum;
    logic [PIX_W+1:0]     diff;
    logic [PIX_W-1:0]     res_value;

    // results of the head job still owed, taken lowest first
    assign rem = head_job.mask & ~done_reg;

    always_comb
    begin
        priority if (rem[RES_ABOVE_LEFT])
            kind = RES_ABOVE_LEFT;
        else if (rem[RES_ABOVE_EDGE])
            kind = RES_ABOVE_EDGE;
        else if (rem[RES_LAST_LEFT])
            kind = RES_LAST_LEFT;
        else
            kind = RES_LAST_EDGE;
    end

    assign sel      = RES_NUM'(1) << kind;
    assign last_one = ((rem & ~sel) == '0);
    assign load     = head_valid && (!out_valid_reg || !out_stall);
    assign pop      = load && last_one;

    always_comb
    begin
        unique case (kind)
            RES_ABOVE_LEFT:
            begin
                op_c    = head_job.up_prev;
                op_l    = head_job.al_left;
                op_u    = head_job.al_up;
                op_r    = head_job.up_cur;
                op_d    = head_job.cur_prev;
                res_col = head_job.col - OUT_COL_W'(1);
                res_row = head_job.row - OUT_ROW_W'(1);
                res_end = 1'b0;
            end
            RES_ABOVE_EDGE:
            begin
                op_c    = head_job.up_cur;
                op_l    = head_job.up_prev;
                op_u    = head_job.ae_up;
                op_r    = head_job.up_cur;
                op_d    = head_job.cur_cur;
                res_col = head_job.col;
                res_row = head_job.row - OUT_ROW_W'(1);
                res_end = 1'b0;
            end
            RES_LAST_LEFT:
            begin
                op_c    = head_job.cur_prev;
                op_l    = head_job.ll_left;
                op_u    = head_job.up_prev;
                op_r    = head_job.cur_cur;
                op_d    = head_job.cur_prev;
                res_col = head_job.col - OUT_COL_W'(1);
                res_row = head_job.row;
                res_end = 1'b0;
            end
            RES_LAST_EDGE:
            begin
                op_c    = head_job.cur_cur;
                op_l    = head_job.cur_prev;
                op_u    = head_job.up_cur;
                op_r    = head_job.cur_cur;
                op_d    = head_job.cur_cur;
                res_col = head_job.col;
                res_row = head_job.row;
                res_end = 1'b1;
            end
            default:
            begin
                op_c    = head_job.cur_cur;
                op_l    = head_job.cur_cur;
                op_u    = head_job.cur_cur;
                op_r    = head_job.cur_cur;
                op_d    = head_job.cur_cur;
                res_col = head_job.col;
                res_row = head_job.row;
                res_end = 1'b0;
            end
        endcase
    end

    // s = 2c - sum/4; negative (wrapped) or >= 255 saturates
    assign sum  = {2'b00, op_l} + {2'b00, op_u} + {2'b00, op_r} + {2'b00, op_d};
    assign diff = {1'b0, op_c, 1'b0} - {2'b00, sum[PIX_W+1:2]};

    always_comb
    begin
        if (diff[PIX_W+1] || (diff[PIX_W:0] >= (PIX_W + 1)'(GAMMA_N)))
            res_value = PIX_SAT;
        else
            res_value = GAMMA_ROM[diff[PIX_W-1:0]];
    end

    always_comb
    begin
        done_next      = done_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            done_next      = last_one ? '0 : (done_reg | sel);
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            value_reg     <= res_value;
            out_col_reg   <= res_col;
            out_row_reg   <= res_row;
            frame_end_reg <= res_end;
        end
    end

    assign value     = value_reg;
    assign out_col   = out_col_reg;
    assign out_row   = out_row_reg;
    assign frame_end = frame_end_reg;
    assign out_valid = out_valid_reg;

    // front never queues a job without results
    `ASSERT_IMPL(a_job_nonempty, clk, rst_n, head_valid, head_job.mask != '0)
    // progress bits stay inside the head job
    `ASSERT_IMPL(a_done_in_mask, clk, rst_n, head_valid, (done_reg & ~head_job.mask) == '0)
    // a job leaves only with its final result
    `ASSERT_IMPL(a_pop_last, clk, rst_n, pop, $onehot(rem))

endmodule

// ===== sv/sharpen_gamma_pixel_stream.sv =====
// Sharpen + gamma pixel stream.
// Input channel (in_valid / in_stall / pixel): one 8-bit pixel per transaction,
// raster order, one color plane per frame. Output channel (out_valid /
// out_stall / value, out_col, out_row, frame_end): one result per transaction,
// tagged with its coordinates; frame_end marks the last result of a frame.
// Config port (cfg_we, cfg_index, cfg_data): 0 = frame_width, 1 = frame_height;
// any write restarts the frame. Write only while the block is idle.
// Results lag the input by one row and one column. The transaction completing a
// neighborhood passes the stage-1 registers, job queue and output register.
// Throughput: one pixel per cycle on ordinary rows while out_stall is low;
// the output side emits one result per cycle, so row ends (two results) are
// absorbed by the job queue, and on the last row (two results per pixel)
// in_stall slows the input, limited by the single result port of the back end.
// A stalled receiver holds the output register; the job queue then fills and
// in_stall rises, with one pixel in flight ahead of the queue.
// Reset: counters, window, queue and output clear; sizes return to 640 x 480.
// Line buffers are not cleared; entries are always written before use.
module sharpen_gamma_pixel_stream #(
    parameter int MAX_WIDTH   = sgps_pkg::MAX_WIDTH_DEF,
    parameter int QUEUE_DEPTH = sgps_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [sgps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sgps_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [sgps_pkg::PIX_W-1:0]      pixel,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [sgps_pkg::PIX_W-1:0]      value,
    output logic [sgps_pkg::OUT_COL_W-1:0]  out_col,
    output logic [sgps_pkg::OUT_ROW_W-1:0]  out_row,
    output logic                            frame_end
);

    import sgps_pkg::*;

    // front -> queue
    logic          push;
    job_t          push_job;
    queue_status_t queue_status;

    // queue -> back
    logic          head_valid;
    job_t          head_job;
    logic          pop;

    // Front: counters, line buffers, 3x3 window, classification into jobs.
    sgps_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pixel        (pixel),
        .push         (push),
        .push_job     (push_job),
        .queue_status (queue_status)
    );

    // Short job queue decoupling the pixel side from result bursts.
    sgps_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .status     (queue_status),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop)
    );

    // Back: one result per cycle while out_stall is low, sharpen + gamma table, output register.
    sgps_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .value      (value),
        .out_col    (out_col),
        .out_row    (out_row),
        .frame_end  (frame_end),
        .out_valid  (out_valid),
        .out_stall  (out_stall)
    );

endmodule
